[hdl/cau_pkg.sv]
`default_nettype none
package cau_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRAC_BITS     = 28;
  localparam int EXPONENT_BITS = 8;
  localparam int OP_BITS       = 3;

  localparam int PROD_W = 2 * WORD_BITS;
  localparam int ACC_W  = 2 * WORD_BITS + 1;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_POW = 3'd3,
    OP_DIV = 3'd4
  } op_e;

  typedef struct packed {
    logic                 ovf;
    logic [WORD_BITS-1:0] val;
  } sat_t;

  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Clamp a wide signed value to the signed word range.
  function automatic sat_t sat_word(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-WORD_BITS:0] hi;
    sat_t                     r;
    hi = x[ACC_W-1:WORD_BITS-1];
    if ((&hi) || !(|hi)) begin
      r.ovf = 1'b0;
      r.val = x[WORD_BITS-1:0];
    end else begin
      r.ovf = 1'b1;
      r.val = x[ACC_W-1] ? WORD_MIN : WORD_MAX;
    end
    return r;
  endfunction

  localparam logic signed [ACC_W-1:0] ONE_ACC = ACC_W'(1) <<< FRAC_BITS;

endpackage
`default_nettype wire

[hdl/complex_arithmetic_unit.sv]
`default_nettype none
// channel | handshake                | payload
// in      | in_valid_i / in_stall_o  | operation_i, a_real_i, a_imag_i, b_real_i, b_imag_i,
//         |                          | exponent_i
// out     | out_valid_o / out_stall_i| z_real_o, z_imag_o, overflowed_o, divide_by_zero_o
//
// One item at a time; in_stall_o is high from acceptance until the result reaches the
// output register. Power makes exponent-1 passes through the one shared 32x32
// multiplier, and divide runs each part of the quotient through the bit-serial divider.
// Reset clears the sequencer and the output valid. A stalled output beat holds while
// the next item is worked on.
module complex_arithmetic_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [cau_pkg::OP_BITS-1:0]          operation_i,
  input  wire logic signed [cau_pkg::WORD_BITS-1:0] a_real_i,
  input  wire logic signed [cau_pkg::WORD_BITS-1:0] a_imag_i,
  input  wire logic signed [cau_pkg::WORD_BITS-1:0] b_real_i,
  input  wire logic signed [cau_pkg::WORD_BITS-1:0] b_imag_i,
  input  wire logic [cau_pkg::EXPONENT_BITS-1:0]    exponent_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [cau_pkg::WORD_BITS-1:0]      z_real_o,
  output logic signed [cau_pkg::WORD_BITS-1:0]      z_imag_o,
  output logic                                      overflowed_o,
  output logic                                      divide_by_zero_o
);

  localparam int W  = cau_pkg::WORD_BITS;
  localparam int F  = cau_pkg::FRAC_BITS;
  localparam int AW = cau_pkg::ACC_W;
  localparam int PW = cau_pkg::PROD_W;
  localparam int EW = cau_pkg::EXPONENT_BITS;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL    = 7'b0000010,
    S_FIN    = 7'b0000100,
    S_DIVCHK = 7'b0001000,
    S_DIVRE  = 7'b0010000,
    S_DIVIM  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  logic [cau_pkg::OP_BITS-1:0] op_q, op_d;
  logic signed [W-1:0]  ar_q, ar_d, ai_q, ai_d, br_q, br_d, bi_q, bi_d;
  logic [EW-1:0]        cnt_q, cnt_d;
  logic [2:0]           ph_q, ph_d;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [AW-1:0] re_q, re_d, im_q, im_d, dd_q, dd_d;
  logic [W-1:0]         rr_q, rr_d, ri_q, ri_d;
  logic                 ovf_q, ovf_d, dz_q, dz_d;
  logic [W-1:0]         zr_q, zr_d, zi_q, zi_d;
  logic                 zo_q, zo_d, zd_q, zd_d;

  logic signed [W-1:0]  mx, my;
  logic signed [AW-1:0] ext;
  logic [2:0]           nph;
  logic                 is_div;
  cau_pkg::sat_t        s_re, s_im, s_one, s_ar, s_ai;
  logic                 div_start, div_done;
  logic signed [AW-1:0] div_num;
  cau_pkg::sat_t        div_res;

  assign is_div = (op_q == cau_pkg::OP_DIV);
  assign nph    = is_div ? 3'd6 : 3'd4;
  assign ext    = AW'(prod_q);
  assign s_re   = cau_pkg::sat_word(re_q >>> F);
  assign s_im   = cau_pkg::sat_word(im_q >>> F);
  assign s_one  = cau_pkg::sat_word(cau_pkg::ONE_ACC);

  always_comb begin
    s_ar = cau_pkg::sat_word(AW'(a_real_i) + AW'(b_real_i));
    s_ai = cau_pkg::sat_word(AW'(a_imag_i) + AW'(b_imag_i));
    if (operation_i == cau_pkg::OP_SUB) begin
      s_ar = cau_pkg::sat_word(AW'(a_real_i) - AW'(b_real_i));
      s_ai = cau_pkg::sat_word(AW'(a_imag_i) - AW'(b_imag_i));
    end
  end

  always_comb begin
    mx = ar_q;
    my = br_q;
    if (is_div) begin
      case (ph_q)
        3'd1:    begin mx = ai_q; my = bi_q; end
        3'd2:    begin mx = ai_q; my = br_q; end
        3'd3:    begin mx = ar_q; my = bi_q; end
        3'd4:    begin mx = br_q; my = br_q; end
        3'd5:    begin mx = bi_q; my = bi_q; end
        default: begin mx = ar_q; my = br_q; end
      endcase
    end else begin
      case (ph_q)
        3'd1:    begin mx = ai_q; my = bi_q; end
        3'd2:    begin mx = ar_q; my = bi_q; end
        3'd3:    begin mx = ai_q; my = br_q; end
        default: begin mx = ar_q; my = br_q; end
      endcase
    end
  end

  assign div_start = (state_q == S_DIVCHK && dd_q != '0) || (state_q == S_DIVRE && div_done);
  assign div_num   = (state_q == S_DIVCHK) ? re_q : im_q;

  cau_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (dd_q[PW-1:0]),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    op_d  = op_q;
    ar_d  = ar_q;  ai_d = ai_q;  br_d = br_q;  bi_d = bi_q;
    cnt_d = cnt_q;
    ph_d  = ph_q;
    prod_d = mx * my;
    re_d  = re_q;  im_d = im_q;  dd_d = dd_q;
    rr_d  = rr_q;  ri_d = ri_q;
    ovf_d = ovf_q; dz_d = dz_q;
    zr_d  = zr_q;  zi_d = zi_q;  zo_d = zo_q;  zd_d = zd_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d  = operation_i;
          ar_d  = a_real_i;  ai_d = a_imag_i;
          br_d  = b_real_i;  bi_d = b_imag_i;
          cnt_d = exponent_i - EW'(1);
          ph_d  = '0;
          rr_d  = '0;  ri_d = '0;
          ovf_d = 1'b0; dz_d = 1'b0;
          state_d = S_DONE;
          case (operation_i) inside
            cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
              rr_d  = s_ar.val;
              ri_d  = s_ai.val;
              ovf_d = s_ar.ovf | s_ai.ovf;
            end
            cau_pkg::OP_MUL, cau_pkg::OP_DIV: begin
              state_d = S_MUL;
            end
            cau_pkg::OP_POW: begin
              if (exponent_i == '0) begin
                rr_d  = s_one.val;
                ovf_d = s_one.ovf;
              end else if (exponent_i == EW'(1)) begin
                rr_d = a_real_i;
                ri_d = a_imag_i;
              end else begin
                br_d    = a_real_i;
                bi_d    = a_imag_i;
                state_d = S_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        // product of phase n lands while phase n+1 is issued
        if (ph_q != '0) begin
          if (is_div) begin
            case (ph_q)
              3'd1:    re_d = ext;
              3'd2:    re_d = re_q + ext;
              3'd3:    im_d = ext;
              3'd4:    im_d = im_q - ext;
              3'd5:    dd_d = ext;
              default: dd_d = dd_q + ext;
            endcase
          end else begin
            case (ph_q)
              3'd1:    re_d = ext;
              3'd2:    re_d = re_q - ext;
              3'd3:    im_d = ext;
              default: im_d = im_q + ext;
            endcase
          end
        end
        ph_d = ph_q + 3'd1;
        if (ph_q == nph) begin
          ph_d    = '0;
          state_d = is_div ? S_DIVCHK : S_FIN;
        end
      end
      S_FIN: begin
        rr_d  = s_re.val;
        ri_d  = s_im.val;
        ovf_d = ovf_q | s_re.ovf | s_im.ovf;
        state_d = S_DONE;
        if (op_q == cau_pkg::OP_POW) begin
          cnt_d = cnt_q - EW'(1);
          if (cnt_q != EW'(1)) begin
            br_d    = s_re.val;
            bi_d    = s_im.val;
            state_d = S_MUL;
          end
        end
      end
      S_DIVCHK: begin
        if (dd_q == '0) begin
          dz_d    = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_DIVRE;
        end
      end
      S_DIVRE: begin
        if (div_done) begin
          rr_d    = div_res.val;
          ovf_d   = ovf_q | div_res.ovf;
          state_d = S_DIVIM;
        end
      end
      S_DIVIM: begin
        if (div_done) begin
          ri_d    = div_res.val;
          ovf_d   = ovf_q | div_res.ovf;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // wait for a free output slot
        if (!out_valid_q || !out_stall_i) begin
          zr_d = rr_q;  zi_d = ri_q;
          zo_d = ovf_q; zd_d = dz_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      ph_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ph_q        <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    ar_q   <= ar_d;  ai_q <= ai_d;  br_q <= br_d;  bi_q <= bi_d;
    cnt_q  <= cnt_d;
    prod_q <= prod_d;
    re_q   <= re_d;  im_q <= im_d;  dd_q <= dd_d;
    rr_q   <= rr_d;  ri_q <= ri_d;
    ovf_q  <= ovf_d; dz_q <= dz_d;
    zr_q   <= zr_d;  zi_q <= zi_d;  zo_q <= zo_d;  zd_q <= zd_d;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign z_real_o         = zr_q;
  assign z_imag_o         = zi_q;
  assign overflowed_o     = zo_q;
  assign divide_by_zero_o = zd_q;

endmodule
`default_nettype wire

[hdl/cau_div.sv]
`default_nettype none
module cau_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [cau_pkg::ACC_W-1:0]    num_i,
  input  wire logic [cau_pkg::PROD_W-1:0]          den_i,
  output logic                                     done_o,
  output cau_pkg::sat_t                            res_o
);

  localparam int W     = cau_pkg::WORD_BITS;
  localparam int F     = cau_pkg::FRAC_BITS;
  localparam int AW    = cau_pkg::ACC_W;
  localparam int DW    = cau_pkg::PROD_W;
  localparam int MW    = AW + F;
  localparam int CNT_W = $clog2(W + 1);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DW-1:0]     rem_q, rem_d;
  logic [DW-1:0]     den_q, den_d;
  logic [W-1:0]      low_q, low_d;
  logic [W-1:0]      quo_q, quo_d;
  logic              neg_q, neg_d;
  logic              big_q, big_d;

  logic [AW-1:0]     mag;
  logic [MW-1:0]     scaled;
  logic [MW-1:0]     hi_ext;
  logic [DW:0]       trial;
  logic [DW:0]       diff;

  always_comb begin
    mag    = num_i[AW-1] ? AW'(-num_i) : AW'(num_i);
    scaled = {mag, {F{1'b0}}};
    hi_ext = MW'(scaled[MW-1:W]);
    trial  = {rem_q, low_q[W-1]};
    diff   = trial - {1'b0, den_q};

    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    low_d  = low_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    big_d  = big_q;

    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      den_d = den_i;
      neg_d = num_i[AW-1];
      big_d = hi_ext >= MW'(den_i);
      // upper part is below the divisor unless the quotient is too big anyway
      rem_d = DW'(scaled[MW-1:W]);
      low_d = scaled[W-1:0];
      quo_d = '0;
    end else if (run_q) begin
      // one quotient bit per cycle
      if (!diff[DW]) begin
        rem_d = diff[DW-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      low_d = {low_q[W-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    low_q <= low_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    big_q <= big_d;
  end

  always_comb begin
    res_o.ovf = 1'b0;
    res_o.val = quo_q;
    if (big_q) begin
      res_o.ovf = 1'b1;
      res_o.val = neg_q ? cau_pkg::WORD_MIN : cau_pkg::WORD_MAX;
    end else if (neg_q) begin
      if (quo_q > cau_pkg::WORD_MIN) begin
        res_o.ovf = 1'b1;
        res_o.val = cau_pkg::WORD_MIN;
      end else begin
        res_o.val = -quo_q;
      end
    end else if (quo_q[W-1]) begin
      res_o.ovf = 1'b1;
      res_o.val = cau_pkg::WORD_MAX;
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic [cau_pkg::OP_BITS-1:0]          op;
    logic signed [cau_pkg::WORD_BITS-1:0] ar, ai, br, bi;
    logic [cau_pkg::EXPONENT_BITS-1:0]    ex;
    int                                   send_idle;
    int                                   recv_stall;
  } job_t;

  typedef struct {
    logic signed [cau_pkg::WORD_BITS-1:0] zr, zi;
    logic                                 ovf, dz;
  } answer_t;

  localparam logic [cau_pkg::OP_BITS-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [cau_pkg::OP_BITS-1:0] OP_SPARE_HI = 3'd7;
  localparam logic signed [cau_pkg::WORD_BITS-1:0] Q_ONE = 32'sh1000_0000;
  localparam int RANDOM_JOBS = 1800;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [cau_pkg::OP_BITS-1:0] operation_i = '0;
  logic signed [cau_pkg::WORD_BITS-1:0] a_real_i = '0, a_imag_i = '0;
  logic signed [cau_pkg::WORD_BITS-1:0] b_real_i = '0, b_imag_i = '0;
  logic [cau_pkg::EXPONENT_BITS-1:0] exponent_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [cau_pkg::WORD_BITS-1:0] z_real_o, z_imag_o;
  logic overflowed_o, divide_by_zero_o;

  job_t    pending_jobs[$];
  answer_t expected_answers[$];
  int      errors = 0;
  int      recv_stall_pct = 0;
  bit      beat_taken = 1'b0;

  complex_arithmetic_unit dut (.*);

  always #5 clk_i = ~clk_i;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t %s: got %h want %h", $time, what, got, want);
    errors++;
  endtask

  function automatic logic signed [cau_pkg::WORD_BITS-1:0] clamp(input wide_t x,
                                                                 inout logic ovf);
    if (x > wide_t'(32'sh7fff_ffff)) begin
      ovf = 1'b1;
      return cau_pkg::WORD_MAX;
    end
    if (x < -wide_t'(64'sh8000_0000)) begin
      ovf = 1'b1;
      return cau_pkg::WORD_MIN;
    end
    return x[cau_pkg::WORD_BITS-1:0];
  endfunction

  function automatic void cplx_mul(input logic signed [cau_pkg::WORD_BITS-1:0] ar, ai, br, bi,
                                   inout logic ovf,
                                   output logic signed [cau_pkg::WORD_BITS-1:0] zr, zi);
    wide_t s;
    s = (wide_t'(ar) * wide_t'(br) - wide_t'(ai) * wide_t'(bi)) >>> cau_pkg::FRAC_BITS;
    zr = clamp(s, ovf);
    s = (wide_t'(ar) * wide_t'(bi) + wide_t'(ai) * wide_t'(br)) >>> cau_pkg::FRAC_BITS;
    zi = clamp(s, ovf);
  endfunction

  // truncate toward zero
  function automatic logic signed [cau_pkg::WORD_BITS-1:0] div_part(input wide_t n,
                                                                    input wide_t d,
                                                                    inout logic ovf);
    wide_t m, q;
    m = (n < 0) ? -n : n;
    q = (m <<< cau_pkg::FRAC_BITS) / d;
    if (n < 0) q = -q;
    return clamp(q, ovf);
  endfunction

  function automatic answer_t predict_answer(input job_t j);
    answer_t r;
    wide_t   d;
    logic signed [cau_pkg::WORD_BITS-1:0] nr, ni;
    r = '{zr: '0, zi: '0, ovf: 1'b0, dz: 1'b0};
    case (j.op)
      cau_pkg::OP_ADD: begin
        r.zr = clamp(wide_t'(j.ar) + wide_t'(j.br), r.ovf);
        r.zi = clamp(wide_t'(j.ai) + wide_t'(j.bi), r.ovf);
      end
      cau_pkg::OP_SUB: begin
        r.zr = clamp(wide_t'(j.ar) - wide_t'(j.br), r.ovf);
        r.zi = clamp(wide_t'(j.ai) - wide_t'(j.bi), r.ovf);
      end
      cau_pkg::OP_MUL: cplx_mul(j.ar, j.ai, j.br, j.bi, r.ovf, r.zr, r.zi);
      cau_pkg::OP_POW: begin
        if (j.ex == 0) begin
          r.zr = Q_ONE;
        end else begin
          r.zr = j.ar;
          r.zi = j.ai;
          for (int k = 1; k < j.ex; k++) begin
            cplx_mul(j.ar, j.ai, r.zr, r.zi, r.ovf, nr, ni);
            r.zr = nr;
            r.zi = ni;
          end
        end
      end
      cau_pkg::OP_DIV: begin
        d = wide_t'(j.br) * wide_t'(j.br) + wide_t'(j.bi) * wide_t'(j.bi);
        if (d == 0) begin
          r.dz = 1'b1;
        end else begin
          r.zr = div_part(wide_t'(j.ar) * wide_t'(j.br) + wide_t'(j.ai) * wide_t'(j.bi), d, r.ovf);
          r.zi = div_part(wide_t'(j.ai) * wide_t'(j.br) - wide_t'(j.ar) * wide_t'(j.bi), d, r.ovf);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic signed [cau_pkg::WORD_BITS-1:0] rand_word();
    logic signed [cau_pkg::WORD_BITS-1:0] w;
    case ($urandom_range(0, 4))
      0: w = $urandom;
      1: w = $signed($urandom) >>> $urandom_range(2, 24);
      2: w = $signed($urandom) >>> 4;
      3: case ($urandom_range(0, 4))
           0: w = cau_pkg::WORD_MAX;
           1: w = cau_pkg::WORD_MIN;
           2: w = '0;
           3: w = -1;
           default: w = Q_ONE;
         endcase
      default: w = $signed($urandom) >>> $urandom_range(3, 6);
    endcase
    return w;
  endfunction

  task automatic add_job(logic [cau_pkg::OP_BITS-1:0] op,
                         logic signed [cau_pkg::WORD_BITS-1:0] ar, ai, br, bi,
                         logic [cau_pkg::EXPONENT_BITS-1:0] ex, int send_idle, int recv_stall);
    job_t j;
    j = '{op: op, ar: ar, ai: ai, br: br, bi: bi, ex: ex,
          send_idle: send_idle, recv_stall: recv_stall};
    pending_jobs.push_back(j);
  endtask

  // accept side: predict on the input beat, check on the output beat
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      job_t j;
      j = pending_jobs.pop_front();
      expected_answers.push_back(predict_answer(j));
      recv_stall_pct = j.recv_stall;
      beat_taken = 1'b1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_answers.size() == 0) begin
        report("unexpected beat", z_real_o, '0);
      end else begin
        want = expected_answers.pop_front();
        if (z_real_o !== want.zr) report("z_real", z_real_o, want.zr);
        if (z_imag_o !== want.zi) report("z_imag", z_imag_o, want.zi);
        if (overflowed_o !== want.ovf) report("overflowed", overflowed_o, want.ovf);
        if (divide_by_zero_o !== want.dz) report("divide_by_zero", divide_by_zero_o, want.dz);
      end
    end
  end

  // drive side: advance only after a beat is taken, hold while stalled
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(0, 99) < recv_stall_pct);
    if (rst_ni && (!in_valid_i || beat_taken)) begin
      beat_taken = 1'b0;
      if (pending_jobs.size() > 0 &&
          $urandom_range(0, 99) >= pending_jobs[0].send_idle) begin
        in_valid_i = 1'b1;
        operation_i = pending_jobs[0].op;
        a_real_i = pending_jobs[0].ar;
        a_imag_i = pending_jobs[0].ai;
        b_real_i = pending_jobs[0].br;
        b_imag_i = pending_jobs[0].bi;
        exponent_i = pending_jobs[0].ex;
      end else begin
        in_valid_i = 1'b0;
      end
    end
  end

  initial begin
    #200ms;
    $display("complex_arithmetic_unit: mismatch");
    $finish;
  end

  initial begin
    int s, r, e;
    logic [cau_pkg::OP_BITS-1:0] op;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_job(cau_pkg::OP_ADD, cau_pkg::WORD_MAX, cau_pkg::WORD_MIN,
            cau_pkg::WORD_MAX, cau_pkg::WORD_MIN, '0, 0, 0);
    add_job(cau_pkg::OP_ADD, 0, -1, 0, 1, '1, 0, 0);
    add_job(cau_pkg::OP_SUB, cau_pkg::WORD_MIN, cau_pkg::WORD_MAX,
            cau_pkg::WORD_MAX, cau_pkg::WORD_MIN, '0, 0, 0);
    add_job(cau_pkg::OP_SUB, -1, -1, -1, -1, '0, 0, 0);
    add_job(cau_pkg::OP_MUL, cau_pkg::WORD_MIN, cau_pkg::WORD_MIN,
            cau_pkg::WORD_MIN, cau_pkg::WORD_MIN, '0, 0, 0);
    add_job(cau_pkg::OP_MUL, cau_pkg::WORD_MAX, cau_pkg::WORD_MIN,
            cau_pkg::WORD_MIN, cau_pkg::WORD_MAX, '0, 0, 0);
    add_job(cau_pkg::OP_MUL, -1, 1, 3, -5, '0, 0, 0);
    add_job(cau_pkg::OP_POW, 12345, -678, 0, 0, 8'd0, 0, 0);
    add_job(cau_pkg::OP_POW, cau_pkg::WORD_MIN, cau_pkg::WORD_MAX, 0, 0, 8'd1, 0, 0);
    add_job(cau_pkg::OP_POW, Q_ONE, 0, 0, 0, 8'd255, 0, 0);
    add_job(cau_pkg::OP_POW, 0, Q_ONE, 0, 0, 8'd7, 0, 0);
    add_job(cau_pkg::OP_POW, cau_pkg::WORD_MAX, cau_pkg::WORD_MAX, 0, 0, 8'd3, 0, 0);
    add_job(cau_pkg::OP_POW, Q_ONE >>> 1, Q_ONE >>> 1, 0, 0, 8'd170, 0, 0);
    add_job(cau_pkg::OP_DIV, Q_ONE, Q_ONE, 0, 0, '0, 0, 0);
    add_job(cau_pkg::OP_DIV, -Q_ONE, 7, 3, -Q_ONE, '0, 0, 0);
    add_job(cau_pkg::OP_DIV, cau_pkg::WORD_MAX, cau_pkg::WORD_MIN, 1, -1, '0, 0, 0);
    add_job(cau_pkg::OP_DIV, cau_pkg::WORD_MIN, cau_pkg::WORD_MIN,
            cau_pkg::WORD_MIN, cau_pkg::WORD_MIN, '0, 0, 0);
    add_job(cau_pkg::OP_DIV, -5, 3, Q_ONE, Q_ONE, '0, 0, 0);
    for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++)
      add_job(cau_pkg::OP_BITS'(c), -1, -1, -1, -1, '1, 0, 0);

    for (int i = 0; i < RANDOM_JOBS; i++) begin
      case (i * 4 / RANDOM_JOBS)
        0: begin s = 0;  r = 0;  end
        1: begin s = 79; r = 0;  end
        2: begin s = 0;  r = 79; end
        default: begin s = 8; r = 8; end
      endcase
      e = $urandom_range(0, 99);
      if (e < 3) op = cau_pkg::OP_BITS'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else op = cau_pkg::OP_BITS'($urandom_range(cau_pkg::OP_ADD, cau_pkg::OP_DIV));
      // keep long power chains rare
      e = ($urandom_range(0, 99) < 4) ? $urandom_range(0, 255) : $urandom_range(0, 12);
      add_job(op, rand_word(), rand_word(),
              ($urandom_range(0, 19) == 0) ? '0 : rand_word(),
              ($urandom_range(0, 19) == 0) ? '0 : rand_word(),
              cau_pkg::EXPONENT_BITS'(e), s, r);
    end

    while (pending_jobs.size() > 0 || expected_answers.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("complex_arithmetic_unit: match");
    end else begin
      $display("complex_arithmetic_unit: mismatch");
    end
    $finish;
  end

endmodule
